>>> sv/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants of the tickless sleep tick compensation block
// ----------------------------------------------------------------------------
package tsc_pkg;

  // counter width default, top level hands it down
  localparam int COUNTER_WIDTH_DEF = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [15:0] TICK_PERIOD_RESET = 16'd31;
  localparam logic [15:0] STOP_COMP_RESET = 16'd0;

  typedef enum logic {
    REG_TICK_PERIOD = 1'b0,
    REG_STOP_COMP   = 1'b1
  } reg_idx_t;

  // long division of the elapsed count, bits resolved per stage
  localparam int DIV_WIDTH = 32;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = DIV_WIDTH / DIV_BITS_PER_STAGE;

  typedef struct packed {
    logic [31:0] expected_idle;
    logic [15:0] count_before;
    logic        sleep_aborted;
    logic        tick_fired;
    logic [15:0] count_after;
  } item_t;

  typedef struct packed {
    logic [15:0] sleep_reload;
    logic [15:0] restart_count;
    logic [15:0] ticks_stepped;
  } result_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic        busy;
    logic [15:0] tick_period;
    logic [15:0] stop_comp;
    logic [31:0] max_ticks;
  } cfg_t;

  // results worked out early, carried alongside the division
  typedef struct packed {
    logic        bypass;
    logic [15:0] reload;
    logic [15:0] restart;
    logic [15:0] ticks;
  } side_t;

  typedef struct packed {
    logic [31:0] dec;
    side_t       side;
  } front_t;

  // nq holds the dividend bits still to be shifted out and the quotient bits
  typedef struct packed {
    logic [DIV_WIDTH-1:0] nq;
    logic [15:0]          rem;
    side_t                side;
  } div_t;

endpackage

>>> sv/tsc_cfg.sv
// ----------------------------------------------------------------------------
// tsc_cfg
// register file and iterative divider for the idle tick limit
// ----------------------------------------------------------------------------
module tsc_cfg #(
  parameter int COUNTER_WIDTH = tsc_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsc_pkg::PADDR_W-1:0] paddr,
  input  logic [tsc_pkg::PDATA_W-1:0] pwdata,
  output logic [tsc_pkg::PDATA_W-1:0] prdata,
  output tsc_pkg::cfg_t               cfg
);
  import tsc_pkg::*;

  localparam int CNT_W = (COUNTER_WIDTH > 1) ? $clog2(COUNTER_WIDTH) : 1;

  logic [15:0]              tick_period;
  logic [15:0]              stop_comp;
  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic [15:0]              rem;
  logic [15:0]              rem_next;
  logic [COUNTER_WIDTH-1:0] quo;
  logic [COUNTER_WIDTH-1:0] quo_next;
  logic [16:0]              rem_sh;
  logic                     ge;
  logic                     wr;
  reg_idx_t                 idx;

  assign wr  = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[PADDR_W-1]);

  // dividend is all ones, so every step shifts in a one
  always_comb begin
    rem_sh   = {rem, 1'b1};
    ge       = rem_sh >= {1'b0, tick_period};
    rem_next = ge ? 16'(rem_sh - {1'b0, tick_period}) : rem_sh[15:0];
    quo_next = {quo[COUNTER_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RESET;
      stop_comp   <= STOP_COMP_RESET;
      busy        <= 1'b1;
      cnt         <= '0;
      rem         <= '0;
      quo         <= '0;
    end else begin
      if (wr) begin
        case (idx)
          REG_TICK_PERIOD: tick_period <= pwdata[15:0];
          REG_STOP_COMP:   stop_comp   <= pwdata[15:0];
          default:         ;
        endcase
      end
      if (wr && idx == REG_TICK_PERIOD) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(COUNTER_WIDTH - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    case (idx)
      REG_TICK_PERIOD: prdata = {16'b0, tick_period};
      REG_STOP_COMP:   prdata = {16'b0, stop_comp};
      default:         prdata = '0;
    endcase
  end

  assign cfg.busy        = busy;
  assign cfg.tick_period = tick_period;
  assign cfg.stop_comp   = stop_comp;
  assign cfg.max_ticks   = 32'(quo);

endmodule

>>> sv/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// clamp, reload and elapsed count stages ahead of the divider
// ----------------------------------------------------------------------------
module tsc_front (
  input  logic            clk,
  input  logic            rst,
  input  tsc_pkg::cfg_t   cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  tsc_pkg::item_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tsc_pkg::front_t dn_data
);
  import tsc_pkg::*;

  logic        v1, v2, v3, v4;
  logic        rdy1, rdy2, rdy3, rdy4;

  logic [31:0] s1_idm1;
  logic [15:0] s1_cb, s1_ca;
  side_t       s1_side;
  logic [31:0] s2_prod;
  logic [15:0] s2_cb, s2_ca;
  side_t       s2_side;
  logic [31:0] s3_reload;
  logic [15:0] s3_cb, s3_ca;
  side_t       s3_side;
  front_t      s4;

  logic [31:0] idle_c, idm1, ab;
  side_t       side1, side3;
  logic [31:0] sum, reload;
  logic [31:0] base, dec;

  assign rdy4     = !v4 || dn_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;

  // stage 1: clamp idle ticks, resolve the aborted and fired cases
  always_comb begin
    idle_c = (up_data.expected_idle > cfg.max_ticks) ? cfg.max_ticks : up_data.expected_idle;
    idm1   = idle_c - 32'd1;
    ab     = {16'b0, up_data.count_before} - {16'b0, cfg.stop_comp};
    side1  = '0;
    if (up_data.sleep_aborted) begin
      side1.bypass = 1'b1;
      if (ab <= 32'd1) begin
        side1.restart = cfg.tick_period;
        side1.ticks   = 16'd1;
      end else begin
        side1.restart = ab[15:0];
        side1.ticks   = 16'd0;
      end
    end else if (up_data.tick_fired) begin
      side1.bypass  = 1'b1;
      side1.restart = up_data.count_after;
      side1.ticks   = idm1[15:0];
    end
  end

  // stage 3: reload less stop compensation
  always_comb begin
    sum    = {16'b0, s2_cb} + s2_prod;
    reload = (sum > {16'b0, cfg.stop_comp}) ? sum - {16'b0, cfg.stop_comp} : sum;
    side3  = s2_side;
    side3.reload = reload[15:0];
  end

  // stage 4: elapsed decrements
  always_comb begin
    base = (s3_reload >= {16'b0, s3_ca}) ? s3_reload - {16'b0, s3_ca} : 32'd1;
    dec  = (cfg.tick_period >= s3_cb) ? base + {16'b0, 16'(cfg.tick_period - s3_cb)} : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_idm1 <= idm1;
      s1_cb   <= up_data.count_before;
      s1_ca   <= up_data.count_after;
      s1_side <= side1;
    end
    if (rdy2) begin
      s2_prod <= 32'(cfg.tick_period * s1_idm1);
      s2_cb   <= s1_cb;
      s2_ca   <= s1_ca;
      s2_side <= s1_side;
    end
    if (rdy3) begin
      s3_reload <= reload;
      s3_cb     <= s2_cb;
      s3_ca     <= s2_ca;
      s3_side   <= side3;
    end
    if (rdy4) begin
      s4.dec  <= dec;
      s4.side <= s3_side;
    end
  end

  assign dn_valid = v4;
  assign dn_data  = s4;

endmodule

>>> sv/tsc_div.sv
// ----------------------------------------------------------------------------
// tsc_div
// pipelined restoring division of the elapsed count by the tick period
// ----------------------------------------------------------------------------
module tsc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     tick_period,
  input  logic            up_valid,
  output logic            up_ready,
  input  tsc_pkg::front_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tsc_pkg::div_t   dn_data
);
  import tsc_pkg::*;

  logic        v   [DIV_STAGES];
  logic        rdy [DIV_STAGES];
  div_t        st  [DIV_STAGES];
  div_t        nxt [DIV_STAGES];
  logic [15:0] dv;

  // a zero period divides by one
  assign dv = (tick_period == 16'd0) ? 16'd1 : tick_period;

  function automatic div_t div_step(input div_t d, input logic [15:0] divisor);
    div_t        r;
    logic [16:0] rs;
    r  = d;
    rs = {d.rem, d.nq[DIV_WIDTH-1]};
    if (rs >= {1'b0, divisor}) begin
      r.rem = 16'(rs - {1'b0, divisor});
      r.nq  = {d.nq[DIV_WIDTH-2:0], 1'b1};
    end else begin
      r.rem = rs[15:0];
      r.nq  = {d.nq[DIV_WIDTH-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    div_t cur;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        cur.nq   = up_data.dec;
        cur.rem  = '0;
        cur.side = up_data.side;
      end else begin
        cur = st[s-1];
      end
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        cur = div_step(cur, dv);
      end
      nxt[s] = cur;
    end
  end

  always_comb begin
    rdy[DIV_STAGES-1] = !v[DIV_STAGES-1] || dn_ready;
    for (int s = DIV_STAGES - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        v[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (rdy[s]) v[s] <= (s == 0) ? up_valid : v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[s]) st[s] <= nxt[s];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v[DIV_STAGES-1];
  assign dn_data  = st[DIV_STAGES-1];

endmodule

>>> sv/tsc_out.sv
// ----------------------------------------------------------------------------
// tsc_out
// restart value and tick step from the quotient, output register
// ----------------------------------------------------------------------------
module tsc_out (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      tick_period,
  input  logic             up_valid,
  output logic             up_ready,
  input  tsc_pkg::div_t    up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output tsc_pkg::result_t dn_data
);
  import tsc_pkg::*;

  logic        v;
  logic        rdy;
  result_t     res;
  result_t     res_next;
  logic [31:0] q;
  logic [31:0] restart;

  assign rdy = !v || dn_ready;

  // (q+1)*period - dec is period - remainder, or -q for a zero period
  always_comb begin
    q       = up_data.nq;
    restart = (tick_period == 16'd0) ? 32'd0 - q
                                     : {16'b0, tick_period} - {16'b0, up_data.rem};
    res_next.sleep_reload = up_data.side.reload;
    if (up_data.side.bypass) begin
      res_next.restart_count = up_data.side.restart;
      res_next.ticks_stepped = up_data.side.ticks;
    end else if (restart <= 32'd1) begin
      res_next.restart_count = tick_period;
      res_next.ticks_stepped = q[15:0] + 16'd1;
    end else begin
      res_next.restart_count = restart[15:0];
      res_next.ticks_stepped = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (rdy) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) res <= res_next;
  end

  assign up_ready = rdy;
  assign dn_valid = v;
  assign dn_data  = res;

endmodule

>>> sv/tickless_sleep_tick_compensation_top.sv
// ----------------------------------------------------------------------------
// tickless_sleep_tick_compensation_top
// per sleep episode reload, restart count and tick step for a tickless idle
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      tsc_pkg::item_t
// result    out        result_valid / result_ready  tsc_pkg::result_t
// config    in         apb psel/penable/pwrite      pwdata, prdata (32 bit)
//
// one item per clock while results are taken and the limit is not busy; each item
// passes 13 register stages: clamp, multiply, reload, elapsed count, 8 divider
// stages, output
// item_ready is low after reset and after every tick_period write, while the
// bit-serial divider works out the idle tick limit
// a stall holds each stage until the next one frees up, so bubbles collapse;
// while a result waits at the output, the front takes transfers until stages fill
//
module tickless_sleep_tick_compensation_top #(
  parameter int COUNTER_WIDTH = tsc_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // item channel
  input  logic                        item_valid,
  output logic                        item_ready,
  input  tsc_pkg::item_t              item,
  // result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output tsc_pkg::result_t            result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsc_pkg::PADDR_W-1:0] paddr,
  input  logic [tsc_pkg::PDATA_W-1:0] pwdata,
  output logic [tsc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import tsc_pkg::*;

  cfg_t   cfg;
  logic   front_valid, front_ready;
  front_t front_data;
  logic   div_valid, div_ready;
  div_t   div_data;
  logic   front_in_ready;
  logic   tp_write;

  assign pready = 1'b1;

  // registers plus the idle tick limit, period max over tick period
  tsc_cfg #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // no transfer while the limit is being recomputed
  assign item_ready = front_in_ready && !cfg.busy;

  // clamp, reload, elapsed count
  tsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (item_valid && !cfg.busy),
    .up_ready (front_in_ready),
    .up_data  (item),
    .dn_valid (front_valid),
    .dn_ready (front_ready),
    .dn_data  (front_data)
  );

  // elapsed count over tick period, four quotient bits a stage
  tsc_div u_div (
    .clk         (clk),
    .rst         (rst),
    .tick_period (cfg.tick_period),
    .up_valid    (front_valid),
    .up_ready    (front_ready),
    .up_data     (front_data),
    .dn_valid    (div_valid),
    .dn_ready    (div_ready),
    .dn_data     (div_data)
  );

  // restart value, tick step and the output register
  tsc_out u_out (
    .clk         (clk),
    .rst         (rst),
    .tick_period (cfg.tick_period),
    .up_valid    (div_valid),
    .up_ready    (div_ready),
    .up_data     (div_data),
    .dn_valid    (result_valid),
    .dn_ready    (result_ready),
    .dn_data     (result)
  );

  assign tp_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_TICK_PERIOD);

  // the limit is never used while it is being worked out
  a_busy_blocks_items: assert property (@(posedge clk) disable iff (rst)
    cfg.busy |-> !item_ready)
    else $error("item transfer taken while idle limit busy");

  // a new tick period closes the item channel from the next cycle
  a_tp_write_recomputes: assert property (@(posedge clk) disable iff (rst)
    tp_write |=> (cfg.busy && !item_ready))
    else $error("tick period write did not start limit division");

  // after reset, the divider only starts on a tick period write
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(cfg.busy) |-> $past(tp_write))
    else $error("limit division started without a tick period write");

endmodule
